>>> rtl/core/assert_macros.svh
// Assertion macros used by circular_deque_unit, the RTL of the circular deque block.
// No dependencies; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on a clock edge, switched off while the synchronous reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication form: when the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/cdq_pkg.sv
// Package for the circular deque block: operation codes and fixed widths.
// No dependencies; used by circular_deque_unit.
package cdq_pkg;

   localparam int WORD_W = 32;
   localparam int CAP_W  = 5;
   localparam int KIND_W = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_STATUS     = 3'd4
   } kind_type;

endpackage

>>> rtl/core/circular_deque_unit.sv
// Circular deque unit: double-ended ring buffer of signed 32-bit words held in
// one synchronous memory. Depends on cdq_pkg and assert_macros.svh.
//
// Each request transaction carries one operation (push front, push back, pop
// front, pop back or status) and gives exactly one response transaction with
// the accepted flag, the front and rear words after the operation (-1 when
// empty) and the empty and full flags. An item goes through the update step
// that writes the memory and moves the pointers, then the registered memory
// read of the front and rear entries, then the load of the response register,
// which waits while the response is stalled. The next request is taken as soon
// as that response register is loaded, while the response may still be
// stalled; no new request is taken before then. The capacity register
// (reset 16, a value of 0 acts as 1 and a value above DEPTH acts as DEPTH) may
// only be written while the block is idle, and writing it empties the deque.
module circular_deque_unit #(
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [cdq_pkg::CAP_W-1:0]        csr_wr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [cdq_pkg::KIND_W-1:0]       req_kind,
   input  logic signed [cdq_pkg::WORD_W-1:0] req_push_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_accepted,
   output logic signed [cdq_pkg::WORD_W-1:0] rsp_front_value,
   output logic signed [cdq_pkg::WORD_W-1:0] rsp_rear_value,
   output logic                             rsp_is_empty,
   output logic                             rsp_is_full
);

`include "assert_macros.svh"

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_LOAD
   } state_type;

   state_type                       state_ff;
   logic [cdq_pkg::CAP_W-1:0]       capacity_ff;
   logic [AW-1:0]                   head_ff, head_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic                            acc_ff, acc_in;
   logic                            wr_en;
   logic [AW-1:0]                   wr_addr;
   logic [AW-1:0]                   rear_addr;
   logic [CW-1:0]                   eff_cap;
   logic [SW-1:0]                   back_sum, next_sum, rear_sum;
   logic                            req_take;
   logic                            rsp_free;
   logic                            is_empty_now;
   logic                            is_full_now;
   logic                            head_legal;

   logic signed [cdq_pkg::WORD_W-1:0] mem [DEPTH];
   logic signed [cdq_pkg::WORD_W-1:0] rd_front_ff;
   logic signed [cdq_pkg::WORD_W-1:0] rd_rear_ff;

   logic                              rsp_valid_ff;
   logic                              rsp_accepted_ff;
   logic signed [cdq_pkg::WORD_W-1:0] rsp_front_ff;
   logic signed [cdq_pkg::WORD_W-1:0] rsp_rear_ff;
   logic                              rsp_is_empty_ff;
   logic                              rsp_is_full_ff;

   // Effective capacity: zero acts as one, anything above DEPTH acts as DEPTH.
   always_comb begin
      if (capacity_ff == '0) begin
         eff_cap = CW'(1);
      end else if (32'(capacity_ff) > 32'(DEPTH)) begin
         eff_cap = CW'(DEPTH);
      end else begin
         eff_cap = CW'(capacity_ff);
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Each sum is below 2x capacity (rear only if nonempty), so one subtract wraps it.
   always_comb begin
      back_sum = SW'(head_ff) + SW'(count_ff);
      if (back_sum >= SW'(eff_cap)) begin
         back_sum = back_sum - SW'(eff_cap);
      end
      next_sum = SW'(head_ff) + SW'(1);
      if (next_sum >= SW'(eff_cap)) begin
         next_sum = next_sum - SW'(eff_cap);
      end
      rear_sum = SW'(head_ff) + SW'(count_ff) - SW'(1);
      if (rear_sum >= SW'(eff_cap)) begin
         rear_sum = rear_sum - SW'(eff_cap);
      end
   end

   assign rear_addr = AW'(rear_sum);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      acc_in   = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = head_ff;
      case (cdq_pkg::kind_type'(req_kind))
         cdq_pkg::KIND_PUSH_FRONT: begin
            if (count_ff < eff_cap) begin
               head_in  = (head_ff == '0) ? AW'(eff_cap - CW'(1)) : head_ff - AW'(1);
               wr_addr  = head_in;
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               acc_in   = 1'b1;
            end
         end
         cdq_pkg::KIND_PUSH_BACK: begin
            if (count_ff < eff_cap) begin
               wr_addr  = AW'(back_sum);
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
               acc_in   = 1'b1;
            end
         end
         cdq_pkg::KIND_POP_FRONT: begin
            if (count_ff != '0) begin
               head_in  = AW'(next_sum);
               count_in = count_ff - CW'(1);
               acc_in   = 1'b1;
            end
         end
         cdq_pkg::KIND_POP_BACK: begin
            if (count_ff != '0) begin
               count_in = count_ff - CW'(1);
               acc_in   = 1'b1;
            end
         end
         cdq_pkg::KIND_STATUS: begin
            acc_in = 1'b1;
         end
         default: begin
            acc_in = 1'b0;
         end
      endcase
   end

   // The write lands at the accept edge, so the reads issued in the next cycle see it.
   always_ff @(posedge clock) begin
      if (req_take && wr_en) begin
         mem[wr_addr] <= req_push_value;
      end
   end

   always_ff @(posedge clock) begin
      rd_front_ff <= mem[head_ff];
      rd_rear_ff  <= mem[rear_addr];
   end

   assign is_empty_now = (count_ff == '0);
   assign is_full_now  = (count_ff == eff_cap);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         capacity_ff  <= cdq_pkg::CAP_RESET;
         head_ff      <= '0;
         count_ff     <= '0;
         acc_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In the load stage the response register is handled below.
         if (rsp_valid_ff && !rsp_stall && state_ff != S_LOAD) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
            head_ff     <= '0;
            count_ff    <= '0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  head_ff  <= head_in;
                  count_ff <= count_in;
                  acc_ff   <= acc_in;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               if (rsp_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_accepted_ff <= acc_ff;
                  rsp_front_ff    <= is_empty_now ? '1 : rd_front_ff;
                  rsp_rear_ff     <= is_empty_now ? '1 : rd_rear_ff;
                  rsp_is_empty_ff <= is_empty_now;
                  rsp_is_full_ff  <= is_full_now;
                  state_ff        <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_rear_value  = rsp_rear_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;
   assign rsp_is_full     = rsp_is_full_ff;

   assign head_legal = (head_ff < AW'(eff_cap)) || (eff_cap == CW'(DEPTH));

   `ASSERT_CLK(a_count_in_range, clock, reset, count_ff <= eff_cap, "count above capacity")
   `ASSERT_CLK(a_head_in_range, clock, reset, head_legal, "head pointer beyond capacity")
   `ASSERT_NEXT(a_take_starts_read, clock, reset, req_take, state_ff == S_READ, "no read")
   `ASSERT_CLK(a_rsp_from_load, clock, reset, !$rose(rsp_valid_ff) || $past(state_ff == S_LOAD), "no load")

endmodule
